// ===== src/uvs_pkg.sv =====
package uvs_pkg;

   localparam int INDEX_BITS       = 10;
   localparam int RADIUS_BITS      = 16;
   localparam int VNUM_BITS        = 21;
   localparam int PHASE_BITS       = 32;
   localparam int TEX_BITS         = 15;
   localparam int DIV_PER_STAGE    = 4;
   localparam int DIV_STAGES       = PHASE_BITS / DIV_PER_STAGE;
   localparam int CORDIC_STEPS     = 16;
   localparam int CORDIC_PER_STAGE = 2;
   localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
   localparam int CORDIC_W         = 34;
   localparam int PROD_STAGES      = 4;
   localparam int TEX_LAT          = CORDIC_STAGES + 2 + PROD_STAGES;
   localparam int BACK_LAT         = DIV_STAGES + TEX_LAT;
   localparam int QUEUE_DEPTH      = 32;
   localparam int QUEUE_AW         = 5;

   localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef enum logic [1:0] {
      CSR_SECTORS = 2'd0,
      CSR_STACKS  = 2'd1,
      CSR_RADIUS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [INDEX_BITS:0] d_ph;
      logic [INDEX_BITS:0] h_ph;
      logic [INDEX_BITS:0] d_tx;
      logic [INDEX_BITS:0] h_tx;
   } div_cfg_type;

   typedef struct packed {
      div_cfg_type             st;
      div_cfg_type             se;
      logic [RADIUS_BITS-1:0]  radius;
   } cfg_type;

   typedef struct packed {
      logic [VNUM_BITS-1:0] k1;
      logic [VNUM_BITS-1:0] k2;
      logic                 up;
      logic                 lo;
   } side_type;

   typedef struct packed {
      logic signed [15:0]   pos_x;
      logic signed [15:0]   pos_y;
      logic signed [15:0]   pos_z;
      logic [15:0]          tex_u;
      logic [15:0]          tex_v;
      logic signed [15:0]   norm_x;
      logic signed [15:0]   norm_y;
      logic signed [15:0]   norm_z;
      side_type             side;
   } rsp_type;

   function automatic logic signed [15:0] sat_pos(input logic signed [48:0] p);
      logic signed [48:0] r;
      r = (p + 49'sd536870912) >>> 30;
      if (r > 49'sd32767) return 16'sd32767;
      if (r < -49'sd32768) return -16'sd32768;
      return r[15:0];
   endfunction

   function automatic logic signed [15:0] sat_norm(input logic signed [31:0] u);
      logic signed [31:0] r;
      r = (u + 32'sd32768) >>> 16;
      if (r > 32'sd16384) return 16'sd16384;
      if (r < -32'sd16384) return -16'sd16384;
      return r[15:0];
   endfunction

endpackage

// ===== src/uvs_div.sv =====
module uvs_div (
   input  logic                              clock,
   input  logic [uvs_pkg::INDEX_BITS-1:0]    idx,
   input  uvs_pkg::div_cfg_type              dc,
   output logic [uvs_pkg::PHASE_BITS-1:0]    phase,
   output logic [uvs_pkg::TEX_BITS:0]        tex
);
   import uvs_pkg::*;

   localparam int RW = INDEX_BITS + 1;

   logic [RW-1:0]         rp_cur [DIV_STAGES];
   logic [RW-1:0]         rp_in  [DIV_STAGES];
   logic [RW-1:0]         rp_ff  [DIV_STAGES];
   logic [RW-1:0]         rt_cur [DIV_STAGES];
   logic [RW-1:0]         rt_in  [DIV_STAGES];
   logic [RW-1:0]         rt_ff  [DIV_STAGES];
   logic [PHASE_BITS-1:0] qp_cur [DIV_STAGES];
   logic [PHASE_BITS-1:0] qp_in  [DIV_STAGES];
   logic [PHASE_BITS-1:0] qp_ff  [DIV_STAGES];
   logic [TEX_BITS-1:0]   qt_cur [DIV_STAGES];
   logic [TEX_BITS-1:0]   qt_in  [DIV_STAGES];
   logic [TEX_BITS-1:0]   qt_ff  [DIV_STAGES];
   logic                  ot_cur [DIV_STAGES];
   logic                  ot_ff  [DIV_STAGES];
   logic [PHASE_BITS-1:0] hp_w;
   logic [TEX_BITS-1:0]   ht_w;
   logic [RW-1:0]         idx_w;

   assign hp_w  = PHASE_BITS'(dc.h_ph);
   assign ht_w  = TEX_BITS'(dc.h_tx);
   assign idx_w = RW'(idx);

   // index equal to the divisor: phase quotient overflows into the dropped top bit, tex keeps it as its top bit
   assign rp_cur[0] = (idx_w == dc.d_ph) ? '0 : idx_w;
   assign rt_cur[0] = (idx_w == dc.d_tx) ? '0 : idx_w;
   assign qp_cur[0] = '0;
   assign qt_cur[0] = '0;
   assign ot_cur[0] = (idx_w == dc.d_tx);

   for (genvar s = 1; s < DIV_STAGES; s++) begin : g_chain
      assign rp_cur[s] = rp_ff[s-1];
      assign rt_cur[s] = rt_ff[s-1];
      assign qp_cur[s] = qp_ff[s-1];
      assign qt_cur[s] = qt_ff[s-1];
      assign ot_cur[s] = ot_ff[s-1];
   end

   always_comb begin
      logic [RW:0]           wide;
      logic [RW-1:0]         rp;
      logic [RW-1:0]         rt;
      logic [PHASE_BITS-1:0] qp;
      logic [TEX_BITS-1:0]   qt;
      int                    t;
      for (int s = 0; s < DIV_STAGES; s++) begin
         rp = rp_cur[s];
         rt = rt_cur[s];
         qp = qp_cur[s];
         qt = qt_cur[s];
         for (int u = 0; u < DIV_PER_STAGE; u++) begin
            t = s * DIV_PER_STAGE + u;
            wide = {rp, hp_w[PHASE_BITS-1-t]};
            if (wide >= {1'b0, dc.d_ph}) begin
               qp = {qp[PHASE_BITS-2:0], 1'b1};
               rp = RW'(wide - {1'b0, dc.d_ph});
            end else begin
               qp = {qp[PHASE_BITS-2:0], 1'b0};
               rp = wide[RW-1:0];
            end
            if (t < TEX_BITS) begin
               wide = {rt, ht_w[TEX_BITS-1-t]};
               if (wide >= {1'b0, dc.d_tx}) begin
                  qt = {qt[TEX_BITS-2:0], 1'b1};
                  rt = RW'(wide - {1'b0, dc.d_tx});
               end else begin
                  qt = {qt[TEX_BITS-2:0], 1'b0};
                  rt = wide[RW-1:0];
               end
            end
         end
         rp_in[s] = rp;
         rt_in[s] = rt;
         qp_in[s] = qp;
         qt_in[s] = qt;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         rp_ff[s] <= rp_in[s];
         rt_ff[s] <= rt_in[s];
         qp_ff[s] <= qp_in[s];
         qt_ff[s] <= qt_in[s];
         ot_ff[s] <= ot_cur[s];
      end
   end

   assign phase = qp_ff[DIV_STAGES-1];
   assign tex   = {ot_ff[DIV_STAGES-1], qt_ff[DIV_STAGES-1]};

endmodule

// ===== src/uvs_cordic.sv =====
module uvs_cordic (
   input  logic                             clock,
   input  logic [uvs_pkg::PHASE_BITS-1:0]   phase,
   output logic signed [31:0]               cos_q,
   output logic signed [31:0]               sin_q
);
   import uvs_pkg::*;

   logic signed [CORDIC_W-1:0] x_cur [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] y_cur [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] z_cur [CORDIC_STAGES];
   logic                       f_cur [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] x_in  [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] y_in  [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] z_in  [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] x_ff  [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] y_ff  [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] z_ff  [CORDIC_STAGES];
   logic                       f_ff  [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] z0_ff;
   logic                       f0_ff;
   logic                       flip;
   logic [31:0]                folded;
   logic signed [31:0]         cos_ff;
   logic signed [31:0]         sin_ff;

   // phases in the second and third quarter turn are folded by a half turn
   assign flip   = phase[31] ^ phase[30];
   assign folded = flip ? {~phase[31], phase[30:0]} : phase;

   always_ff @(posedge clock) begin
      f0_ff <= flip;
      z0_ff <= {{(CORDIC_W-32){folded[31]}}, folded};
   end

   assign x_cur[0] = CORDIC_W'(CORDIC_GAIN);
   assign y_cur[0] = '0;
   assign z_cur[0] = z0_ff;
   assign f_cur[0] = f0_ff;

   for (genvar s = 1; s < CORDIC_STAGES; s++) begin : g_chain
      assign x_cur[s] = x_ff[s-1];
      assign y_cur[s] = y_ff[s-1];
      assign z_cur[s] = z_ff[s-1];
      assign f_cur[s] = f_ff[s-1];
   end

   always_comb begin
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;
      logic signed [CORDIC_W-1:0] at;
      int                         k;
      for (int s = 0; s < CORDIC_STAGES; s++) begin
         x = x_cur[s];
         y = y_cur[s];
         z = z_cur[s];
         for (int u = 0; u < CORDIC_PER_STAGE; u++) begin
            k  = s * CORDIC_PER_STAGE + u;
            dx = y >>> k;
            dy = x >>> k;
            at = CORDIC_W'(ATAN_TURNS[k]);
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - at;
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + at;
            end
         end
         x_in[s] = x;
         y_in[s] = y;
         z_in[s] = z;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < CORDIC_STAGES; s++) begin
         x_ff[s] <= x_in[s];
         y_ff[s] <= y_in[s];
         z_ff[s] <= z_in[s];
         f_ff[s] <= f_cur[s];
      end
      cos_ff <= f_ff[CORDIC_STAGES-1] ? 32'(-x_ff[CORDIC_STAGES-1])
                                      : 32'(x_ff[CORDIC_STAGES-1]);
      sin_ff <= f_ff[CORDIC_STAGES-1] ? 32'(-y_ff[CORDIC_STAGES-1])
                                      : 32'(y_ff[CORDIC_STAGES-1]);
   end

   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

// ===== src/uvs_front.sv =====
module uvs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [uvs_pkg::INDEX_BITS-1:0]   stack_index,
   input  logic [uvs_pkg::INDEX_BITS-1:0]   sector_index,
   input  logic                             csr_valid,
   input  logic [1:0]                       csr_index,
   input  logic [uvs_pkg::RADIUS_BITS-1:0]  csr_data,
   output logic                             csr_ready,
   output uvs_pkg::cfg_type                 cfg,
   output logic                             item_valid,
   output logic [uvs_pkg::INDEX_BITS-1:0]   item_i,
   output logic [uvs_pkg::INDEX_BITS-1:0]   item_j,
   output uvs_pkg::side_type                item_side
);
   import uvs_pkg::*;

   logic [INDEX_BITS-1:0]  sector_count_ff;
   logic [INDEX_BITS-1:0]  stack_count_ff;
   logic [RADIUS_BITS-1:0] radius_ff;
   logic [INDEX_BITS-1:0]  sectors;
   logic [INDEX_BITS-1:0]  stacks;
   logic [INDEX_BITS-1:0]  i_in;
   logic [INDEX_BITS-1:0]  j_in;
   logic                   in_grid;
   side_type               side_in;
   logic                   valid_ff;
   logic [INDEX_BITS-1:0]  i_ff;
   logic [INDEX_BITS-1:0]  j_ff;
   side_type               side_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_count_ff <= INDEX_BITS'(36);
         stack_count_ff  <= INDEX_BITS'(18);
         radius_ff       <= RADIUS_BITS'(4096);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SECTORS: sector_count_ff <= csr_data[INDEX_BITS-1:0];
            CSR_STACKS:  stack_count_ff  <= csr_data[INDEX_BITS-1:0];
            CSR_RADIUS:  radius_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   assign sectors = (sector_count_ff < INDEX_BITS'(3)) ? INDEX_BITS'(3) : sector_count_ff;
   assign stacks  = (stack_count_ff < INDEX_BITS'(2)) ? INDEX_BITS'(2) : stack_count_ff;

   // stack phase divides i*2^32 by 2*stacks so both axes share one divider shape
   assign cfg.se.d_ph = {1'b0, sectors};
   assign cfg.se.h_ph = {2'b0, sectors[INDEX_BITS-1:1]};
   assign cfg.se.d_tx = {1'b0, sectors};
   assign cfg.se.h_tx = {2'b0, sectors[INDEX_BITS-1:1]};
   assign cfg.st.d_ph = {stacks, 1'b0};
   assign cfg.st.h_ph = {1'b0, stacks[INDEX_BITS-1:1], 1'b0};
   assign cfg.st.d_tx = {1'b0, stacks};
   assign cfg.st.h_tx = {2'b0, stacks[INDEX_BITS-1:1]};
   assign cfg.radius  = radius_ff;

   assign i_in    = (stack_index > stacks) ? stacks : stack_index;
   assign j_in    = (sector_index > sectors) ? sectors : sector_index;
   assign in_grid = (i_in < stacks) && (j_in < sectors);

   always_comb begin
      side_in.k1 = VNUM_BITS'(i_in) * VNUM_BITS'({1'b0, sectors} + 11'd1)
                   + VNUM_BITS'(j_in);
      side_in.k2 = side_in.k1 + VNUM_BITS'(sectors) + VNUM_BITS'(1);
      side_in.up = in_grid && (i_in != '0);
      side_in.lo = in_grid && (i_in != stacks - INDEX_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      side_ff <= side_in;
   end

   assign item_valid = valid_ff;
   assign item_i     = i_ff;
   assign item_j     = j_ff;
   assign item_side  = side_ff;

endmodule

// ===== src/uvs_back.sv =====
module uvs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  uvs_pkg::cfg_type                 cfg,
   input  logic                             item_valid,
   input  logic [uvs_pkg::INDEX_BITS-1:0]   item_i,
   input  logic [uvs_pkg::INDEX_BITS-1:0]   item_j,
   input  uvs_pkg::side_type                item_side,
   output logic                             out_valid,
   output uvs_pkg::rsp_type                 out_word
);
   import uvs_pkg::*;

   logic [PHASE_BITS-1:0]  st_q;
   logic [PHASE_BITS-1:0]  se_q;
   logic [PHASE_BITS-1:0]  st_phase;
   logic [TEX_BITS:0]      st_tex;
   logic [TEX_BITS:0]      se_tex;
   logic signed [31:0]     cst;
   logic signed [31:0]     sst;
   logic signed [31:0]     cse;
   logic signed [31:0]     sse;
   logic signed [63:0]     cc_ff;
   logic signed [63:0]     cs_ff;
   logic signed [31:0]     sz1_ff;
   logic signed [63:0]     ux_w;
   logic signed [63:0]     uy_w;
   logic signed [31:0]     ux_ff;
   logic signed [31:0]     uy_ff;
   logic signed [31:0]     sz2_ff;
   logic signed [16:0]     rad_s;
   logic signed [48:0]     px_ff;
   logic signed [48:0]     py_ff;
   logic signed [48:0]     pz_ff;
   logic signed [31:0]     ux3_ff;
   logic signed [31:0]     uy3_ff;
   logic signed [31:0]     sz3_ff;
   logic signed [15:0]     pos_x_ff;
   logic signed [15:0]     pos_y_ff;
   logic signed [15:0]     pos_z_ff;
   logic signed [15:0]     norm_x_ff;
   logic signed [15:0]     norm_y_ff;
   logic signed [15:0]     norm_z_ff;
   logic                   valid_ff [BACK_LAT];
   side_type               side_ff  [BACK_LAT];
   logic [TEX_BITS:0]      tu_ff    [TEX_LAT];
   logic [TEX_BITS:0]      tv_ff    [TEX_LAT];

   uvs_div u_div_st (
      .clock (clock),
      .idx   (item_i),
      .dc    (cfg.st),
      .phase (st_q),
      .tex   (st_tex)
   );

   uvs_div u_div_se (
      .clock (clock),
      .idx   (item_j),
      .dc    (cfg.se),
      .phase (se_q),
      .tex   (se_tex)
   );

   assign st_phase = QUARTER_TURN - st_q;

   uvs_cordic u_cordic_st (
      .clock (clock),
      .phase (st_phase),
      .cos_q (cst),
      .sin_q (sst)
   );

   uvs_cordic u_cordic_se (
      .clock (clock),
      .phase (se_q),
      .cos_q (cse),
      .sin_q (sse)
   );

   assign ux_w  = (cc_ff + 64'sd536870912) >>> 30;
   assign uy_w  = (cs_ff + 64'sd536870912) >>> 30;
   assign rad_s = {1'b0, cfg.radius};

   always_ff @(posedge clock) begin
      cc_ff     <= cst * cse;
      cs_ff     <= cst * sse;
      sz1_ff    <= sst;
      ux_ff     <= ux_w[31:0];
      uy_ff     <= uy_w[31:0];
      sz2_ff    <= sz1_ff;
      px_ff     <= rad_s * ux_ff;
      py_ff     <= rad_s * uy_ff;
      pz_ff     <= rad_s * sz2_ff;
      ux3_ff    <= ux_ff;
      uy3_ff    <= uy_ff;
      sz3_ff    <= sz2_ff;
      pos_x_ff  <= sat_pos(px_ff);
      pos_y_ff  <= sat_pos(py_ff);
      pos_z_ff  <= sat_pos(pz_ff);
      norm_x_ff <= sat_norm(ux3_ff);
      norm_y_ff <= sat_norm(uy3_ff);
      norm_z_ff <= sat_norm(sz3_ff);
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= item_side;
      for (int s = 1; s < BACK_LAT; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
      tu_ff[0] <= se_tex;
      tv_ff[0] <= st_tex;
      for (int s = 1; s < TEX_LAT; s++) begin
         tu_ff[s] <= tu_ff[s-1];
         tv_ff[s] <= tv_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < BACK_LAT; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= item_valid;
         for (int s = 1; s < BACK_LAT; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   assign out_valid       = valid_ff[BACK_LAT-1];
   assign out_word.pos_x  = pos_x_ff;
   assign out_word.pos_y  = pos_y_ff;
   assign out_word.pos_z  = pos_z_ff;
   assign out_word.tex_u  = tu_ff[TEX_LAT-1];
   assign out_word.tex_v  = tv_ff[TEX_LAT-1];
   assign out_word.norm_x = norm_x_ff;
   assign out_word.norm_y = norm_y_ff;
   assign out_word.norm_z = norm_z_ff;
   assign out_word.side   = side_ff[BACK_LAT-1];

endmodule

// ===== src/uvs_queue.sv =====
module uvs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  uvs_pkg::rsp_type   wr_word,
   input  logic               rd_en,
   output logic               empty,
   output uvs_pkg::rsp_type   rd_word
);
   import uvs_pkg::*;

   rsp_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;
   logic                  head_valid_ff;
   rsp_type               head_ff;
   logic                  load;

   // head register refills from the array whenever the array holds a word and the head is free or being popped
   assign load = (count_ff != '0) && (!head_valid_ff || rd_en);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_word;
      end
      if (load) begin
         head_ff <= mem_ff[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (load) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         count_ff <= count_ff + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(load);
         if (load) begin
            head_valid_ff <= 1'b1;
         end else if (rd_en) begin
            head_valid_ff <= 1'b0;
         end
      end
   end

   assign empty   = !head_valid_ff;
   assign rd_word = head_ff;

endmodule

// ===== src/uv_sphere_vertex_generator.sv =====
// Latitude-longitude sphere vertex generator. Push one grid point (stack row,
// sector column) per cycle while full is low; one result word comes out per
// point, in order, with position, normal, texture coordinates, vertex numbers and
// triangle flags. Sustained rate is one word per clock while full stays low. Index
// clamp and vertex numbering register at the edge that accepts the point, then
// come eight register stages for the radix-2 restoring dividers (four quotient
// bits per stage), ten for the CORDIC pair (two rotations per stage plus fold and
// sign stages), four for the products, rounding and saturation, one to write the
// queue and one to load its output register. Results land in a 32-entry queue;
// full is driven by a credit count of words in flight plus words queued, so
// throughput stays at one per clock as long as pop keeps up.
// The CSR channel is always ready; write it only while the block is drained.
module uv_sphere_vertex_generator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [uvs_pkg::INDEX_BITS-1:0]   req_stack_index,
   input  logic [uvs_pkg::INDEX_BITS-1:0]   req_sector_index,
   output logic                             empty,
   input  logic                             pop,
   output logic signed [15:0]               rsp_pos_x,
   output logic signed [15:0]               rsp_pos_y,
   output logic signed [15:0]               rsp_pos_z,
   output logic [15:0]                      rsp_tex_u,
   output logic [15:0]                      rsp_tex_v,
   output logic signed [15:0]               rsp_norm_x,
   output logic signed [15:0]               rsp_norm_y,
   output logic signed [15:0]               rsp_norm_z,
   output logic [uvs_pkg::VNUM_BITS-1:0]    rsp_vertex_number,
   output logic [uvs_pkg::VNUM_BITS-1:0]    rsp_below_vertex_number,
   output logic                             rsp_upper_triangle_valid,
   output logic                             rsp_lower_triangle_valid,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [1:0]                       csr_index,
   input  logic [uvs_pkg::RADIUS_BITS-1:0]  csr_data
);
   import uvs_pkg::*;

   logic                   accept;
   logic                   pop_ok;
   logic [QUEUE_AW:0]      credit_ff;
   cfg_type                cfg;
   logic                   item_valid;
   logic [INDEX_BITS-1:0]  item_i;
   logic [INDEX_BITS-1:0]  item_j;
   side_type               item_side;
   logic                   back_valid;
   rsp_type                back_word;
   rsp_type                head;

   assign full   = (credit_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign accept = push && !full;
   assign pop_ok = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_ff + (QUEUE_AW+1)'(accept) - (QUEUE_AW+1)'(pop_ok);
      end
   end

   uvs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .stack_index  (req_stack_index),
      .sector_index (req_sector_index),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .csr_ready    (csr_ready),
      .cfg          (cfg),
      .item_valid   (item_valid),
      .item_i       (item_i),
      .item_j       (item_j),
      .item_side    (item_side)
   );

   uvs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item_i     (item_i),
      .item_j     (item_j),
      .item_side  (item_side),
      .out_valid  (back_valid),
      .out_word   (back_word)
   );

   uvs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (back_valid),
      .wr_word (back_word),
      .rd_en   (pop_ok),
      .empty   (empty),
      .rd_word (head)
   );

   assign rsp_pos_x                = head.pos_x;
   assign rsp_pos_y                = head.pos_y;
   assign rsp_pos_z                = head.pos_z;
   assign rsp_tex_u                = head.tex_u;
   assign rsp_tex_v                = head.tex_v;
   assign rsp_norm_x               = head.norm_x;
   assign rsp_norm_y               = head.norm_y;
   assign rsp_norm_z               = head.norm_z;
   assign rsp_vertex_number        = head.side.k1;
   assign rsp_below_vertex_number  = head.side.k2;
   assign rsp_upper_triangle_valid = head.side.up;
   assign rsp_lower_triangle_valid = head.side.lo;

endmodule
